/* src/ked_pkg.sv */
// Shared constants and types for the Kirsch compass edge detector.
// No dependencies; used by the top level and its port checker.
`default_nettype none

package ked_pkg;

    localparam int PIX_W         = 8;
    localparam int IMG_W_W       = 11;
    localparam int IMG_H_W       = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int NUM_DIR       = 8;
    localparam int RESP_W        = 14;

    localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd640;
    localparam logic [IMG_H_W-1:0] IMG_H_RST = 16'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic signed [RESP_W-1:0] resp_t;

endpackage

`default_nettype wire

/* src/kirsch_edge_detector.sv */
// Kirsch compass edge detector, 3x3, streaming raster pixels.
// Two line-store memories, a 3x3 window and a response/max pipeline; uses ked_pkg.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------
//  in       | into      | in_valid / in_stall   | pixel, frame_start
//  out      | out of    | out_valid / out_stall | edge_res, last
//  cfg      | into      | cfg_we                | cfg_index, cfg_data
//
// One pixel request per cycle while in_stall is low; a result leaves after its
// pixel passes the registered line-store read plus window, response and
// max stages. The whole pipeline advances only when the output register is free
// or being taken; otherwise in_stall rises. Reset clears counters, window and
// valid bits; line-store contents stay undefined until written.
`default_nettype none

module kirsch_edge_detector #(
    parameter int MAX_WIDTH = ked_pkg::MAX_WIDTH_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire  [ked_pkg::PIX_W-1:0]          pixel,
    input  wire                                frame_start,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [ked_pkg::PIX_W-1:0]          edge_res,
    output logic                               last,
    input  wire                                cfg_we,
    input  wire  [ked_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [ked_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW0 = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (WW0 > ked_pkg::IMG_W_W) ? WW0 : ked_pkg::IMG_W_W;
    localparam int HW  = ked_pkg::IMG_H_W;

    logic [ked_pkg::IMG_W_W-1:0] img_w_reg;
    logic [HW-1:0]               img_h_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [HW-1:0] row_reg, row_next;

    logic          adv, accept;
    logic [EW-1:0] w_eff, c_ext, iw_ext;
    logic [CW-1:0] c_cur;
    logic [HW-1:0] r_cur, row_inc;
    logic          emit, is_last, wrap;

    ked_pkg::pix_t mem_upper [MAX_WIDTH];
    ked_pkg::pix_t mem_middle [MAX_WIDTH];
    ked_pkg::pix_t up_rd_reg, mid_rd_reg;
    ked_pkg::pix_t fwd_up_reg, fwd_mid_reg;
    logic          fwd_reg;

    logic          s1_valid_reg, s1_emit_reg, s1_last_reg;
    logic [CW-1:0] s1_col_reg;
    ked_pkg::pix_t s1_pix_reg;
    ked_pkg::pix_t s1_top, s1_mid;

    ked_pkg::pix_t win_reg [3][3];
    logic          s2_valid_reg, s2_last_reg;

    ked_pkg::resp_t resp_reg [ked_pkg::NUM_DIR];
    logic           s3_valid_reg, s3_last_reg;

    ked_pkg::pix_t g [ked_pkg::NUM_DIR];
    logic [10:0]   total;
    logic [9:0]    three [ked_pkg::NUM_DIR];
    ked_pkg::resp_t resp [ked_pkg::NUM_DIR];
    ked_pkg::resp_t tot3;

    ked_pkg::resp_t best;
    ked_pkg::pix_t  res_clamp;

    logic          out_valid_reg, out_last_reg;
    ked_pkg::pix_t out_res_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= ked_pkg::IMG_W_RST;
            img_h_reg <= ked_pkg::IMG_H_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ked_pkg::CFG_IMAGE_WIDTH:  img_w_reg <= cfg_data[ked_pkg::IMG_W_W-1:0];
                ked_pkg::CFG_IMAGE_HEIGHT: img_h_reg <= cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    assign adv      = !out_valid_reg || !out_stall;
    assign accept   = in_valid && adv;
    assign in_stall = !adv;

    // position and result flags of the incoming request
    always_comb
    begin
        iw_ext = EW'(img_w_reg);
        if (iw_ext > EW'(MAX_WIDTH))
            w_eff = EW'(MAX_WIDTH);
        else if (iw_ext == '0)
            w_eff = EW'(1);
        else
            w_eff = iw_ext;

        c_cur   = frame_start ? '0 : col_reg;
        r_cur   = frame_start ? '0 : row_reg;
        c_ext   = EW'(c_cur);
        emit    = (w_eff >= EW'(3)) && (img_h_reg >= HW'(3)) && (c_ext >= EW'(2))
                  && (c_ext < w_eff) && (r_cur >= HW'(2)) && (r_cur < img_h_reg);
        is_last = (r_cur == img_h_reg - HW'(1)) && (c_ext == w_eff - EW'(1));
        wrap    = (c_ext + EW'(1)) >= w_eff;
        row_inc = r_cur + HW'(1);
        if (wrap)
        begin
            col_next = '0;
            row_next = (row_inc == img_h_reg) ? '0 : row_inc;
        end
        else
        begin
            col_next = c_cur + CW'(1);
            row_next = r_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores: read on request, write back one stage later
    assign s1_top = fwd_reg ? fwd_up_reg  : up_rd_reg;
    assign s1_mid = fwd_reg ? fwd_mid_reg : mid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
            mem_upper[s1_col_reg] <= s1_mid;
        if (accept)
            up_rd_reg <= mem_upper[c_cur];
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
            mem_middle[s1_col_reg] <= s1_pix_reg;
        if (accept)
            mid_rd_reg <= mem_middle[c_cur];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_reg     <= s1_valid_reg && (s1_col_reg == c_cur);
            fwd_up_reg  <= s1_mid;
            fwd_mid_reg <= s1_pix_reg;
            s1_col_reg  <= c_cur;
            s1_pix_reg  <= pixel;
            s1_emit_reg <= emit;
            s1_last_reg <= is_last;
        end
    end

    // window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
        end
        else if (adv && s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= s1_top;
            win_reg[1][2] <= s1_mid;
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    // compass responses
    always_comb
    begin
        g[0] = win_reg[0][0];
        g[1] = win_reg[0][1];
        g[2] = win_reg[0][2];
        g[3] = win_reg[1][2];
        g[4] = win_reg[2][2];
        g[5] = win_reg[2][1];
        g[6] = win_reg[2][0];
        g[7] = win_reg[1][0];
        total = ((11'(g[0]) + 11'(g[1])) + (11'(g[2]) + 11'(g[3])))
              + ((11'(g[4]) + 11'(g[5])) + (11'(g[6]) + 11'(g[7])));
        tot3  = ked_pkg::resp_t'({3'b000, total}) + ked_pkg::resp_t'({2'b00, total, 1'b0});
        for (int k = 0; k < ked_pkg::NUM_DIR; k++)
        begin
            three[k] = 10'(g[k]) + 10'(g[(k + 1) % ked_pkg::NUM_DIR])
                     + 10'(g[(k + 2) % ked_pkg::NUM_DIR]);
            resp[k]  = ked_pkg::resp_t'({1'b0, three[k], 3'b000}) - tot3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < ked_pkg::NUM_DIR; k++)
                resp_reg[k] <= resp[k];
            s3_last_reg <= s2_last_reg;
        end
    end

    // maximum and clamp
    always_comb
    begin
        best = '0;
        for (int k = 0; k < ked_pkg::NUM_DIR; k++)
            if (resp_reg[k] > best)
                best = resp_reg[k];
        if (best > ked_pkg::resp_t'(255))
            res_clamp = 8'hFF;
        else
            res_clamp = best[ked_pkg::PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_last_reg  <= s1_last_reg;
            out_res_reg  <= res_clamp;
            out_last_reg <= s3_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign edge_res  = out_res_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

/* src/ked_checker.sv */
// Port-level checks for the Kirsch compass edge detector.
// Watches the top-level ports only; bound to kirsch_edge_detector, uses ked_pkg.
`default_nettype none

module ked_checker (
    input wire                       clk,
    input wire                       rst_n,
    input wire                       in_stall,
    input wire                       out_valid,
    input wire                       out_stall,
    input wire [ked_pkg::PIX_W-1:0]  edge_res,
    input wire                       last
);

    a_idle_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("request stalled while output register empty");

    a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("request stalled while output is draining");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(edge_res) && $stable(last))
        else $error("result changed under stall");

endmodule

bind kirsch_edge_detector ked_checker u_ked_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .edge_res  (edge_res),
    .last      (last)
);

`default_nettype wire
